// ===== design/hecb_pkg.sv =====
// hecb_pkg: shared types, codes and size defaults for the half-edge builder
// used by every module of the block but hecb_ram; no dependencies

package hecb_pkg;

  localparam int unsigned DEF_MAX_HALF_EDGES = 4096;
  localparam int unsigned DEF_MAX_VERTICES   = 4096;
  localparam int unsigned DEF_MAX_FACES      = 2048;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned VID_W   = 12;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned LIMIT_W = 13;
  localparam int unsigned FACE_W  = 11;
  localparam int unsigned BND_W   = 13;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 3'd0,
    CMD_ADD     = 3'd1,
    CMD_FINISH  = 3'd2,
    CMD_RD_EDGE = 3'd3,
    CMD_RD_VERT = 3'd4
  } cmd_e_t;

  typedef enum logic [2:0] {
    STS_OK    = 3'd0,
    STS_FULL  = 3'd1,
    STS_RANGE = 3'd2,
    STS_OPEN  = 3'd3,
    STS_BADV  = 3'd4,
    STS_STALE = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_ADD,
    OP_FINISH,
    OP_RD_EDGE,
    OP_RD_VERT,
    OP_BADV,
    OP_RANGE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [VID_W-1:0] vid;
    logic             closes;
    logic [IDX_W-1:0] idx;
  } hecb_op_t;

  typedef struct packed {
    status_t          status;
    logic [11:0]      edge_index;
    logic [11:0]      origin_vertex;
    logic [FACE_W-1:0] owning_face;
    logic [11:0]      next_edge;
    logic [11:0]      prev_edge;
    logic [11:0]      twin_edge;
    logic             has_twin;
    logic [BND_W-1:0] boundary_count;
    logic [11:0]      vertex_edge;
    logic             vertex_has_edge;
  } hecb_res_t;

  typedef enum logic [4:0] {
    ST_CLR,
    ST_IDLE,
    ST_ADD_LINK,
    ST_RDE,
    ST_RDV,
    ST_HCLR,
    ST_D_NXT,
    ST_D_ORG,
    ST_D_SRC,
    ST_D_HEAD,
    ST_D_LINK,
    ST_P_ORG,
    ST_P_DST,
    ST_P_HEAD,
    ST_P_LOOK,
    ST_W_CHK
  } state_t;

endpackage

// ===== design/hecb_ram.sv =====
// hecb_ram: generic single write port, single read port ram with registered read
// no dependencies

module hecb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/hecb_front.sv =====
// hecb_front: takes command words, holds the vertex limit register and sorts
// each word into an operation for the back end; uses hecb_pkg

module hecb_front
  import hecb_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               q_full,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [VID_W-1:0]   in_vertex_id,
  input  logic               in_closes_face,
  input  logic [IDX_W-1:0]   in_lookup_index,
  input  logic               cfg_valid,
  input  logic [LIMIT_W-1:0] cfg_vertex_limit,
  output logic               busy,
  output logic               push,
  output hecb_op_t           push_data
);

  logic [LIMIT_W-1:0] limit_r;
  logic [31:0]        active;
  logic               vid_ok;
  logic               idx_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid) begin
      limit_r <= cfg_vertex_limit;
    end
  end

  assign active = (32'(limit_r) < 32'(MAX_VERTICES)) ? 32'(limit_r) : 32'(MAX_VERTICES);
  assign vid_ok = 32'(in_vertex_id) < active;
  assign idx_ok = 32'(in_lookup_index) < active;

  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    push_data.vid    = in_vertex_id;
    push_data.closes = in_closes_face;
    push_data.idx    = in_lookup_index;
    unique case (in_command)
      CMD_CLEAR:   push_data.op = OP_CLEAR;
      CMD_ADD:     push_data.op = vid_ok ? OP_ADD : OP_BADV;
      CMD_FINISH:  push_data.op = OP_FINISH;
      CMD_RD_EDGE: push_data.op = OP_RD_EDGE;
      CMD_RD_VERT: push_data.op = idx_ok ? OP_RD_VERT : OP_RANGE;
      default:     push_data.op = OP_RANGE;
    endcase
  end

endmodule

// ===== design/hecb_queue.sv =====
// hecb_queue: two-word queue of sorted operations between front and back end
// uses hecb_pkg

module hecb_queue
  import hecb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  hecb_op_t push_data,
  input  logic     pop,
  output logic     full,
  output logic     q_valid,
  output hecb_op_t q_data
);

  hecb_op_t   slot_r [0:1];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

  assign full    = cnt_r == 2'd2;
  assign q_valid = cnt_r != 2'd0;
  assign q_data  = slot_r[rp_r];

endmodule

// ===== design/hecb_back.sv =====
// hecb_back: carries out operations on the half-edge and vertex memories,
// including the twin pairing pass; uses hecb_pkg and hecb_ram

module hecb_back
  import hecb_pkg::*;
#(
  parameter int unsigned MAX_HALF_EDGES = DEF_MAX_HALF_EDGES,
  parameter int unsigned MAX_VERTICES   = DEF_MAX_VERTICES,
  parameter int unsigned MAX_FACES      = DEF_MAX_FACES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  hecb_op_t  q_data,
  output logic      q_pop,
  output logic      res_valid,
  output hecb_res_t res
);

  localparam int unsigned EW = $clog2(MAX_HALF_EDGES);
  localparam int unsigned EC = $clog2(MAX_HALF_EDGES + 1);
  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned FC = $clog2(MAX_FACES + 1);

  state_t state_r, st_nxt;

  logic [EC-1:0] edge_total_r, edge_total_nxt;
  logic [FC-1:0] face_total_r, face_total_nxt;
  logic          open_r, open_nxt;
  logic [EW-1:0] first_r, first_nxt;
  logic          twins_ok_r, twins_ok_nxt;
  logic [VW-1:0] sw_r, sw_nxt;
  logic          clr_ans_r, clr_ans_nxt;
  logic [EW-1:0] e_r, e_nxt;
  logic [VW-1:0] v0_r, v0_nxt;
  logic [EW-1:0] f_r, f_nxt;
  logic [EC-1:0] bnd_r, bnd_nxt;
  hecb_op_t      op_r, op_nxt;
  hecb_res_t     res_r, res_nxt;
  logic          res_valid_r, res_valid_nxt;

  // ram ports
  logic          org_we, face_we, next_we, prev_we, twin_we, dest_we, chain_we, vout_we, head_we;
  logic [EW-1:0] org_wa, face_wa, next_wa, prev_wa, twin_wa, dest_wa, chain_wa;
  logic [EW-1:0] org_ra, face_ra, next_ra, prev_ra, twin_ra, dest_ra, chain_ra;
  logic [VW-1:0] vout_wa, head_wa, vout_ra, head_ra;
  logic [VW-1:0] org_wd, org_rd, dest_wd, dest_rd;
  logic [FC-1:0] face_wd, face_rd;
  logic [EC-1:0] next_wd, next_rd;
  logic [EW-1:0] prev_wd, prev_rd;
  logic [EW:0]   twin_wd, twin_rd, chain_wd, chain_rd, vout_wd, vout_rd, head_wd, head_rd;

  hecb_ram #(.WIDTH(VW), .DEPTH(MAX_HALF_EDGES)) u_origin (
    .clk, .wr_en(org_we), .wr_addr(org_wa), .wr_data(org_wd), .rd_addr(org_ra),
    .rd_data(org_rd));
  hecb_ram #(.WIDTH(FC), .DEPTH(MAX_HALF_EDGES)) u_face (
    .clk, .wr_en(face_we), .wr_addr(face_wa), .wr_data(face_wd), .rd_addr(face_ra),
    .rd_data(face_rd));
  hecb_ram #(.WIDTH(EC), .DEPTH(MAX_HALF_EDGES)) u_next (
    .clk, .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd), .rd_addr(next_ra),
    .rd_data(next_rd));
  hecb_ram #(.WIDTH(EW), .DEPTH(MAX_HALF_EDGES)) u_prev (
    .clk, .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd), .rd_addr(prev_ra),
    .rd_data(prev_rd));
  hecb_ram #(.WIDTH(EW + 1), .DEPTH(MAX_HALF_EDGES)) u_twin (
    .clk, .wr_en(twin_we), .wr_addr(twin_wa), .wr_data(twin_wd), .rd_addr(twin_ra),
    .rd_data(twin_rd));
  hecb_ram #(.WIDTH(VW), .DEPTH(MAX_HALF_EDGES)) u_dest (
    .clk, .wr_en(dest_we), .wr_addr(dest_wa), .wr_data(dest_wd), .rd_addr(dest_ra),
    .rd_data(dest_rd));
  hecb_ram #(.WIDTH(EW + 1), .DEPTH(MAX_HALF_EDGES)) u_chain (
    .clk, .wr_en(chain_we), .wr_addr(chain_wa), .wr_data(chain_wd), .rd_addr(chain_ra),
    .rd_data(chain_rd));
  hecb_ram #(.WIDTH(EW + 1), .DEPTH(MAX_VERTICES)) u_vout (
    .clk, .wr_en(vout_we), .wr_addr(vout_wa), .wr_data(vout_wd), .rd_addr(vout_ra),
    .rd_data(vout_rd));
  hecb_ram #(.WIDTH(EW + 1), .DEPTH(MAX_VERTICES)) u_head (
    .clk, .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd), .rd_addr(head_ra),
    .rd_data(head_rd));

  logic [EW-1:0] e_new;
  logic [EW-1:0] add_first;
  logic          add_full;
  logic          rd_oob;
  logic          sweep_done;
  logic [EC-1:0] e_inc;
  logic          last;
  logic [EW-1:0] nx_wrap;
  logic          pair_done;
  logic          pair_found;
  logic          look_hit;

  assign e_new      = EW'(edge_total_r);
  assign add_first  = open_r ? first_r : e_new;
  assign add_full   = (edge_total_r >= EC'(MAX_HALF_EDGES)) ||
                      (!open_r && (face_total_r >= FC'(MAX_FACES)));
  assign rd_oob     = 32'(q_data.idx) >= 32'(edge_total_r);
  assign sweep_done = sw_r == VW'(MAX_VERTICES - 1);
  assign e_inc      = EC'(e_r) + EC'(1);
  assign last       = e_inc == edge_total_r;
  // next index of an open last slot points one past the store
  assign nx_wrap    = (next_rd == EC'(MAX_HALF_EDGES)) ? '0 : EW'(next_rd);
  assign look_hit   = dest_rd == v0_r;

  // resolution of the chain walk for the current edge
  always_comb begin
    pair_done  = 1'b0;
    pair_found = 1'b0;
    if (state_r == ST_P_LOOK) begin
      pair_done = !head_rd[EW];
    end else if (state_r == ST_W_CHK) begin
      pair_found = look_hit;
      pair_done  = look_hit || !chain_rd[EW];
    end
  end

  // next state
  always_comb begin
    st_nxt = state_r;
    unique case (state_r)
      ST_CLR: begin
        if (sweep_done) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_data.op)
            OP_CLEAR:   st_nxt = ST_CLR;
            OP_ADD:     st_nxt = add_full ? ST_IDLE : ST_ADD_LINK;
            OP_FINISH:  st_nxt = open_r ? ST_IDLE : ST_HCLR;
            OP_RD_EDGE: st_nxt = rd_oob ? ST_IDLE : ST_RDE;
            OP_RD_VERT: st_nxt = ST_RDV;
            default:    st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD_LINK, ST_RDE, ST_RDV: st_nxt = ST_IDLE;
      ST_HCLR: begin
        if (sweep_done) st_nxt = (edge_total_r == '0) ? ST_IDLE : ST_D_NXT;
      end
      ST_D_NXT:  st_nxt = ST_D_ORG;
      ST_D_ORG:  st_nxt = ST_D_SRC;
      ST_D_SRC:  st_nxt = ST_D_HEAD;
      ST_D_HEAD: st_nxt = ST_D_LINK;
      ST_D_LINK: st_nxt = last ? ST_P_ORG : ST_D_NXT;
      ST_P_ORG:  st_nxt = ST_P_DST;
      ST_P_DST:  st_nxt = ST_P_HEAD;
      ST_P_HEAD: st_nxt = ST_P_LOOK;
      ST_P_LOOK, ST_W_CHK: begin
        if (pair_done) st_nxt = last ? ST_IDLE : ST_P_ORG;
        else st_nxt = ST_W_CHK;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // outputs, memory controls and datapath updates
  always_comb begin
    q_pop          = 1'b0;
    edge_total_nxt = edge_total_r;
    face_total_nxt = face_total_r;
    open_nxt       = open_r;
    first_nxt      = first_r;
    twins_ok_nxt   = twins_ok_r;
    sw_nxt         = sw_r;
    clr_ans_nxt    = clr_ans_r;
    e_nxt          = e_r;
    v0_nxt         = v0_r;
    f_nxt          = f_r;
    bnd_nxt        = bnd_r;
    op_nxt         = op_r;
    res_nxt        = '0;
    res_nxt.status = STS_OK;
    res_valid_nxt  = 1'b0;

    org_we = 1'b0;  org_wa = '0;  org_wd = '0;  org_ra = '0;
    face_we = 1'b0; face_wa = '0; face_wd = '0; face_ra = '0;
    next_we = 1'b0; next_wa = '0; next_wd = '0; next_ra = '0;
    prev_we = 1'b0; prev_wa = '0; prev_wd = '0; prev_ra = '0;
    twin_we = 1'b0; twin_wa = '0; twin_wd = '0; twin_ra = '0;
    dest_we = 1'b0; dest_wa = '0; dest_wd = '0; dest_ra = '0;
    chain_we = 1'b0; chain_wa = '0; chain_wd = '0; chain_ra = '0;
    vout_we = 1'b0; vout_wa = '0; vout_wd = '0; vout_ra = '0;
    head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;

    unique case (state_r)
      ST_CLR: begin
        vout_we = 1'b1;
        vout_wa = sw_r;
        sw_nxt  = sw_r + VW'(1);
        if (sweep_done) begin
          sw_nxt        = '0;
          clr_ans_nxt   = 1'b0;
          res_valid_nxt = clr_ans_r;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          op_nxt = q_data;
          unique case (q_data.op)
            OP_CLEAR: begin
              edge_total_nxt = '0;
              face_total_nxt = '0;
              open_nxt       = 1'b0;
              first_nxt      = '0;
              twins_ok_nxt   = 1'b0;
              sw_nxt         = '0;
              clr_ans_nxt    = 1'b1;
            end
            OP_ADD: begin
              if (add_full) begin
                res_valid_nxt  = 1'b1;
                res_nxt.status = STS_FULL;
              end else begin
                org_we  = 1'b1;
                org_wa  = e_new;
                org_wd  = VW'(q_data.vid);
                face_we = 1'b1;
                face_wa = e_new;
                face_wd = face_total_r;
                next_we = 1'b1;
                next_wa = e_new;
                next_wd = q_data.closes ? EC'(add_first) : edge_total_r + EC'(1);
                prev_we = 1'b1;
                prev_wa = e_new;
                prev_wd = open_r ? e_new - EW'(1) : e_new;
                vout_ra = VW'(q_data.vid);
                edge_total_nxt = edge_total_r + EC'(1);
                twins_ok_nxt   = 1'b0;
                e_nxt          = e_new;
                f_nxt          = add_first;
                if (q_data.closes) begin
                  face_total_nxt = face_total_r + FC'(1);
                  open_nxt       = 1'b0;
                end else begin
                  open_nxt  = 1'b1;
                  first_nxt = add_first;
                end
              end
            end
            OP_FINISH: begin
              if (open_r) begin
                res_valid_nxt  = 1'b1;
                res_nxt.status = STS_OPEN;
              end else begin
                sw_nxt  = '0;
                bnd_nxt = '0;
              end
            end
            OP_RD_EDGE: begin
              if (rd_oob) begin
                res_valid_nxt      = 1'b1;
                res_nxt.status     = STS_RANGE;
                res_nxt.edge_index = q_data.idx;
              end else begin
                org_ra  = EW'(q_data.idx);
                face_ra = EW'(q_data.idx);
                next_ra = EW'(q_data.idx);
                prev_ra = EW'(q_data.idx);
                twin_ra = EW'(q_data.idx);
              end
            end
            OP_RD_VERT: begin
              vout_ra = VW'(q_data.idx);
            end
            OP_BADV: begin
              res_valid_nxt  = 1'b1;
              res_nxt.status = STS_BADV;
            end
            default: begin
              res_valid_nxt  = 1'b1;
              res_nxt.status = STS_RANGE;
            end
          endcase
        end
      end
      ST_ADD_LINK: begin
        // first edge out of a vertex is kept
        vout_wa = VW'(op_r.vid);
        vout_wd = {1'b1, e_r};
        vout_we = !vout_rd[EW];
        prev_we = op_r.closes;
        prev_wa = f_r;
        prev_wd = e_r;
        res_valid_nxt      = 1'b1;
        res_nxt.edge_index = 12'(e_r);
      end
      ST_RDE: begin
        res_valid_nxt         = 1'b1;
        res_nxt.status        = twins_ok_r ? STS_OK : STS_STALE;
        res_nxt.edge_index    = op_r.idx;
        res_nxt.origin_vertex = 12'(org_rd);
        res_nxt.owning_face   = FACE_W'(face_rd);
        res_nxt.next_edge     = 12'(next_rd);
        res_nxt.prev_edge     = 12'(prev_rd);
        if (twins_ok_r && twin_rd[EW]) begin
          res_nxt.twin_edge = 12'(twin_rd[EW-1:0]);
          res_nxt.has_twin  = 1'b1;
        end
      end
      ST_RDV: begin
        res_valid_nxt = 1'b1;
        if (vout_rd[EW]) begin
          res_nxt.vertex_edge     = 12'(vout_rd[EW-1:0]);
          res_nxt.vertex_has_edge = 1'b1;
        end
      end
      ST_HCLR: begin
        head_we = 1'b1;
        head_wa = sw_r;
        sw_nxt  = sw_r + VW'(1);
        if (sweep_done) begin
          sw_nxt = '0;
          e_nxt  = '0;
          if (edge_total_r == '0) begin
            twins_ok_nxt  = 1'b1;
            res_valid_nxt = 1'b1;
          end
        end
      end
      ST_D_NXT: begin
        next_ra = e_r;
      end
      ST_D_ORG: begin
        org_ra = nx_wrap;
      end
      ST_D_SRC: begin
        dest_we = 1'b1;
        dest_wa = e_r;
        dest_wd = org_rd;
        org_ra  = e_r;
      end
      ST_D_HEAD: begin
        v0_nxt  = org_rd;
        head_ra = org_rd;
      end
      ST_D_LINK: begin
        // chain each edge to the previous one leaving the same vertex
        chain_we = 1'b1;
        chain_wa = e_r;
        chain_wd = head_rd;
        head_we  = 1'b1;
        head_wa  = v0_r;
        head_wd  = {1'b1, e_r};
        e_nxt    = last ? '0 : EW'(e_inc);
      end
      ST_P_ORG: begin
        org_ra = e_r;
      end
      ST_P_DST: begin
        v0_nxt  = org_rd;
        dest_ra = e_r;
      end
      ST_P_HEAD: begin
        head_ra = dest_rd;
      end
      ST_P_LOOK, ST_W_CHK: begin
        if (pair_done) begin
          twin_we = 1'b1;
          twin_wa = e_r;
          twin_wd = pair_found ? {1'b1, f_r} : '0;
          bnd_nxt = bnd_r + EC'(!pair_found);
          e_nxt   = EW'(e_inc);
          if (last) begin
            twins_ok_nxt           = 1'b1;
            res_valid_nxt          = 1'b1;
            res_nxt.boundary_count = BND_W'(bnd_nxt);
          end
        end else begin
          // candidate from head on first look, from the chain afterwards
          f_nxt    = (state_r == ST_P_LOOK) ? head_rd[EW-1:0] : chain_rd[EW-1:0];
          dest_ra  = f_nxt;
          chain_ra = f_nxt;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      edge_total_r <= '0;
      face_total_r <= '0;
      open_r       <= 1'b0;
      first_r      <= '0;
      twins_ok_r   <= 1'b0;
      sw_r         <= '0;
      clr_ans_r    <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      state_r      <= st_nxt;
      edge_total_r <= edge_total_nxt;
      face_total_r <= face_total_nxt;
      open_r       <= open_nxt;
      first_r      <= first_nxt;
      twins_ok_r   <= twins_ok_nxt;
      sw_r         <= sw_nxt;
      clr_ans_r    <= clr_ans_nxt;
      res_valid_r  <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r   <= e_nxt;
    v0_r  <= v0_nxt;
    f_r   <= f_nxt;
    bnd_r <= bnd_nxt;
    op_r  <= op_nxt;
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ===== design/half_edge_connectivity_build.sv =====
// half_edge_connectivity_build: top level of the half-edge builder
// uses hecb_pkg, hecb_front, hecb_queue, hecb_back

// Commands are taken when start is high and busy is low; busy only means the
// two-word command queue is full. Each command gives exactly one result word,
// shown for a single cycle with out_valid; the receiver cannot hold it off.
// Back end: an add corner writes the edge, then links it in ADD_LINK; read edge
// and read vertex read the memories, then answer from RDE or RDV; errors are
// answered from idle. Clear sweeps the vertex table; the same sweep runs after
// reset, commands queue up meanwhile. Finish empties the per-vertex chain heads,
// builds the chains half-edge by half-edge, then hunts each twin along the chain
// of its destination vertex; these chain walks set its length.
// The vertex limit may be written at any time the block is idle.

module half_edge_connectivity_build
  import hecb_pkg::*;
#(
  parameter int unsigned MAX_HALF_EDGES = DEF_MAX_HALF_EDGES,
  parameter int unsigned MAX_VERTICES   = DEF_MAX_VERTICES,
  parameter int unsigned MAX_FACES      = DEF_MAX_FACES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [VID_W-1:0]   in_vertex_id,
  input  logic               in_closes_face,
  input  logic [IDX_W-1:0]   in_lookup_index,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [11:0]        out_edge_index,
  output logic [11:0]        out_origin_vertex,
  output logic [FACE_W-1:0]  out_owning_face,
  output logic [11:0]        out_next_edge,
  output logic [11:0]        out_prev_edge,
  output logic [11:0]        out_twin_edge,
  output logic               out_has_twin,
  output logic [BND_W-1:0]   out_boundary_count,
  output logic [11:0]        out_vertex_edge,
  output logic               out_vertex_has_edge,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_vertex_limit
);

  logic      q_full;
  logic      push;
  hecb_op_t  push_data;
  logic      pop;
  logic      q_valid;
  hecb_op_t  q_data;
  hecb_res_t res;

  assign cfg_ready = 1'b1;

  hecb_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk, .rst_n, .start, .q_full,
    .in_command, .in_vertex_id, .in_closes_face, .in_lookup_index,
    .cfg_valid, .cfg_vertex_limit,
    .busy, .push, .push_data
  );

  hecb_queue u_queue (
    .clk, .rst_n, .push, .push_data, .pop,
    .full(q_full), .q_valid, .q_data
  );

  hecb_back #(
    .MAX_HALF_EDGES(MAX_HALF_EDGES),
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_FACES(MAX_FACES)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_data, .q_pop(pop),
    .res_valid(out_valid), .res
  );

  assign out_status          = res.status;
  assign out_edge_index      = res.edge_index;
  assign out_origin_vertex   = res.origin_vertex;
  assign out_owning_face     = res.owning_face;
  assign out_next_edge       = res.next_edge;
  assign out_prev_edge       = res.prev_edge;
  assign out_twin_edge       = res.twin_edge;
  assign out_has_twin        = res.has_twin;
  assign out_boundary_count  = res.boundary_count;
  assign out_vertex_edge     = res.vertex_edge;
  assign out_vertex_has_edge = res.vertex_has_edge;

endmodule

// ===== tb/half_edge_connectivity_build_tb.sv =====
// half_edge_connectivity_build_tb: self-checking bench for the half-edge builder
// scoreboards every result word against a behavioural mesh model kept in the bench
// depends on hecb_pkg and half_edge_connectivity_build

module half_edge_connectivity_build_tb;
  import hecb_pkg::*;

  localparam int NE = DEF_MAX_HALF_EDGES;
  localparam int NV = DEF_MAX_VERTICES;
  localparam int NF = DEF_MAX_FACES;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [CMD_W-1:0]   in_command = '0;
  logic [VID_W-1:0]   in_vertex_id = '0;
  logic               in_closes_face = 1'b0;
  logic [IDX_W-1:0]   in_lookup_index = '0;
  logic               out_valid;
  logic [2:0]         out_status;
  logic [11:0]        out_edge_index, out_origin_vertex, out_next_edge, out_prev_edge;
  logic [FACE_W-1:0]  out_owning_face;
  logic [11:0]        out_twin_edge, out_vertex_edge;
  logic               out_has_twin, out_vertex_has_edge;
  logic [BND_W-1:0]   out_boundary_count;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_vertex_limit = '0;

  half_edge_connectivity_build u_top (.*);

  always #10 clk = ~clk;

  // mesh model state
  logic [LIMIT_W-1:0] vlimit;
  logic [11:0] e_org [NE];
  logic [10:0] e_fac [NE];
  int          e_nxt [NE];
  int          e_prv [NE];
  int          e_twn [NE];
  bit          e_twn_ok [NE];
  int          v_out [NV];
  bit          v_out_ok [NV];
  int          n_edges, n_faces, face_first;
  bit          face_open, twins_ok;

  hecb_res_t expected_words[$];
  int        n_err = 0;
  bit        gaps_on = 1'b1;

  function automatic void mesh_clear();
    foreach (v_out_ok[i]) begin
      v_out_ok[i] = 1'b0;
      v_out[i] = 0;
    end
    n_edges = 0;
    n_faces = 0;
    face_first = 0;
    face_open = 1'b0;
    twins_ok = 1'b0;
  endfunction

  function automatic int active_limit();
    return (vlimit < NV) ? int'(vlimit) : NV;
  endfunction

  function automatic int pair_mesh();
    int bnd, f;
    logic [11:0] v0, v1;
    bit hit;
    bnd = 0;
    for (int e = 0; e < n_edges; e++) begin
      v0 = e_org[e];
      v1 = e_org[e_nxt[e] % NE];
      hit = 1'b0;
      f = n_edges;
      while (f > 0) begin
        f--;
        if (e_org[f] == v1 && e_org[e_nxt[f] % NE] == v0) begin
          hit = 1'b1;
          break;
        end
      end
      e_twn_ok[e] = hit;
      e_twn[e] = hit ? f : 0;
      if (!hit) bnd++;
    end
    return bnd;
  endfunction

  function automatic hecb_res_t mesh_step(logic [2:0] c, logic [11:0] v, logic cl,
                                          logic [11:0] ix);
    hecb_res_t r;
    int e;
    r = '0;
    r.status = STS_OK;
    case (c)
      CMD_CLEAR: mesh_clear();
      CMD_ADD: begin
        if (v >= active_limit()) r.status = STS_BADV;
        else if (n_edges >= NE || (!face_open && n_faces >= NF)) r.status = STS_FULL;
        else begin
          e = n_edges;
          if (!face_open) begin
            face_open = 1'b1;
            face_first = e;
            e_prv[e] = e;
          end else e_prv[e] = e - 1;
          e_org[e] = v;
          e_fac[e] = n_faces[10:0];
          e_nxt[e] = e + 1;
          if (!v_out_ok[v]) begin
            v_out_ok[v] = 1'b1;
            v_out[v] = e;
          end
          if (cl) begin
            e_nxt[e] = face_first;
            e_prv[face_first % NE] = e;
            n_faces++;
            face_open = 1'b0;
          end
          n_edges = e + 1;
          twins_ok = 1'b0;
          r.edge_index = e[11:0];
        end
      end
      CMD_FINISH: begin
        if (face_open) r.status = STS_OPEN;
        else begin
          r.boundary_count = BND_W'(pair_mesh());
          twins_ok = 1'b1;
        end
      end
      CMD_RD_EDGE: begin
        r.edge_index = ix;
        if (ix >= n_edges) r.status = STS_RANGE;
        else begin
          r.origin_vertex = e_org[ix];
          r.owning_face = e_fac[ix];
          r.next_edge = e_nxt[ix][11:0];
          r.prev_edge = e_prv[ix][11:0];
          if (!twins_ok) r.status = STS_STALE;
          else if (e_twn_ok[ix]) begin
            r.twin_edge = e_twn[ix][11:0];
            r.has_twin = 1'b1;
          end
        end
      end
      CMD_RD_VERT: begin
        if (ix >= active_limit()) r.status = STS_RANGE;
        else if (v_out_ok[ix]) begin
          r.vertex_edge = v_out[ix][11:0];
          r.vertex_has_edge = 1'b1;
        end
      end
      default: r.status = STS_RANGE;
    endcase
    return r;
  endfunction

  task automatic cmp_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      n_err++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    hecb_res_t x;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        n_err++;
      end else begin
        x = expected_words.pop_front();
        cmp_field("status", x.status, out_status);
        cmp_field("edge_index", x.edge_index, out_edge_index);
        cmp_field("origin_vertex", x.origin_vertex, out_origin_vertex);
        cmp_field("owning_face", x.owning_face, out_owning_face);
        cmp_field("next_edge", x.next_edge, out_next_edge);
        cmp_field("prev_edge", x.prev_edge, out_prev_edge);
        cmp_field("twin_edge", x.twin_edge, out_twin_edge);
        cmp_field("has_twin", x.has_twin, out_has_twin);
        cmp_field("boundary_count", x.boundary_count, out_boundary_count);
        cmp_field("vertex_edge", x.vertex_edge, out_vertex_edge);
        cmp_field("vertex_has_edge", x.vertex_has_edge, out_vertex_has_edge);
      end
    end
  end

  task automatic send_word(logic [2:0] c, logic [11:0] v = '0, logic cl = 1'b0,
                           logic [11:0] ix = '0);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 6) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start <= 1'b1;
    in_command <= c;
    in_vertex_id <= v;
    in_closes_face <= cl;
    in_lookup_index <= ix;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_words.push_back(mesh_step(c, v, cl, ix));
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] val);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_vertex_limit <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    vlimit = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    send_word(CMD_RD_VERT, 0, 0, 0);
    send_word(CMD_RD_EDGE, 0, 0, 0);
    send_word(CMD_FINISH);
    // single-corner face pairs with itself
    send_word(CMD_ADD, 12'hFFF, 1'b1);
    send_word(CMD_RD_EDGE, 0, 0, 0);
    send_word(CMD_FINISH);
    send_word(CMD_RD_EDGE, 0, 0, 0);
    // open triangle: links still provisional
    send_word(CMD_ADD, 0);
    send_word(CMD_ADD, 1);
    send_word(CMD_RD_EDGE, 0, 0, 2);
    send_word(CMD_FINISH);
    send_word(CMD_ADD, 2, 1'b1);
    send_word(CMD_ADD, 2);
    send_word(CMD_ADD, 1);
    send_word(CMD_ADD, 3, 1'b1);
    send_word(CMD_FINISH);
    for (int i = 1; i < 7; i++) send_word(CMD_RD_EDGE, 0, 0, i);
    send_word(CMD_RD_EDGE, 0, 0, 12'hFFF);
    send_word(CMD_RD_VERT, 0, 0, 12'hFFF);
    send_word(3'd5);
    send_word(3'd7, 12'hFFF, 1'b1, 12'hFFF);
    send_word(CMD_CLEAR);
  endtask

  task automatic test_limits();
    write_limit(13'd0);
    send_word(CMD_ADD, 0, 1'b1);
    send_word(CMD_RD_VERT, 0, 0, 0);
    write_limit(13'd1);
    send_word(CMD_ADD, 1, 1'b1);
    send_word(CMD_ADD, 0, 1'b1);
    send_word(CMD_RD_VERT, 0, 0, 0);
    send_word(CMD_RD_VERT, 0, 0, 1);
    write_limit(13'h1FFF);
    send_word(CMD_ADD, 12'hFFF, 1'b1);
    send_word(CMD_RD_VERT, 0, 0, 12'hFFF);
    send_word(CMD_CLEAR);
    write_limit(LIMIT_RESET);
  endtask

  task automatic test_random(int n_items);
    logic [11:0] pool [8];
    int sent, lim, corners;
    sent = 0;
    while (sent < n_items) begin
      if (sent > n_items - 150) gaps_on = 1'b0;
      if (sent % 200 < 15 && sent > 0 && $urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: write_limit(LIMIT_RESET);
          1: write_limit(13'h1FFF);
          2: write_limit(13'($urandom_range(1, 64)));
          default: write_limit(13'($urandom_range(1, 8191)));
        endcase
      end
      if ($urandom_range(0, 9) == 0) drain();
      lim = active_limit();
      if (n_edges > 150 || $urandom_range(0, 3) == 0) begin
        send_word(CMD_CLEAR);
        sent++;
      end
      foreach (pool[i])
        pool[i] = ($urandom_range(0, 9) == 0 || lim == 0) ? 12'($urandom)
                  : 12'($urandom_range(0, lim - 1));
      repeat ($urandom_range(1, 5)) begin
        corners = $urandom_range(1, 5);
        for (int k = 0; k < corners; k++) begin
          send_word(CMD_ADD, pool[$urandom_range(0, 7)], k == corners - 1);
          sent++;
        end
      end
      // noise: stray commands in the middle of a build
      repeat ($urandom_range(0, 3)) begin
        case ($urandom_range(0, 4))
          0: send_word(3'($urandom_range(5, 7)), 12'($urandom), 1'($urandom), 12'($urandom));
          1: send_word(CMD_RD_EDGE, 0, 0, 12'($urandom));
          2: send_word(CMD_RD_VERT, 0, 0, 12'($urandom));
          3: send_word(CMD_ADD, 12'($urandom), 1'b0);
          default: send_word(CMD_FINISH);
        endcase
        sent++;
      end
      if (face_open) begin
        send_word(CMD_ADD, pool[0], 1'b1);
        sent++;
      end
      send_word(CMD_FINISH);
      sent++;
      repeat ($urandom_range(2, 8)) begin
        if ($urandom_range(0, 2) != 0 && n_edges > 0)
          send_word(CMD_RD_EDGE, 0, 0, 12'($urandom_range(0, n_edges - 1)));
        else
          send_word(CMD_RD_VERT, 0, 0, pool[$urandom_range(0, 7)]);
        sent++;
      end
    end
  endtask

  initial begin
    vlimit = LIMIT_RESET;
    mesh_clear();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_limits();
    test_random(1150);
    drain();
    repeat (20) @(posedge clk);
    if (n_err == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2_000_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
design/hecb_pkg.sv
design/hecb_ram.sv
design/hecb_front.sv
design/hecb_queue.sv
design/hecb_back.sv
design/half_edge_connectivity_build.sv
tb/half_edge_connectivity_build_tb.sv
